// File: hw/rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared widths and constants of the equidistant trigger placer.
// ----------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

  localparam int unsigned CoordW = 24;  // vertex / trigger coordinate
  localparam int unsigned DistW  = 40;  // arc length
  localparam int unsigned IdxW   = 32;  // trigger index
  localparam int unsigned SpcW   = 24;  // spacing register
  localparam int unsigned LenW   = 25;  // rounded segment length
  localparam int unsigned MagW   = 25;  // magnitude of a coordinate delta
  localparam int unsigned SqW    = 50;  // sum of squares
  localparam int unsigned DvdW   = 52;  // divider dividend
  localparam int unsigned DvsW   = 26;  // divider divisor

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [DistW-1:0]  dist_t;

endpackage

`default_nettype wire

// File: hw/rtl/pet_if.sv
// ----------------------------------------------------------------------------
// pet_if
// Valid/ready channels of the trigger placer: vertex in, trigger out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface pet_vertex_if;
  logic                valid;
  logic                ready;
  pet_pkg::coord_t     vertex_x;
  pet_pkg::coord_t     vertex_y;
  logic                path_start;
  modport source (output valid, vertex_x, vertex_y, path_start, input ready);
  modport sink   (input valid, vertex_x, vertex_y, path_start, output ready);
endinterface

interface pet_trigger_if;
  logic                valid;
  logic                ready;
  pet_pkg::coord_t     trigger_x;
  pet_pkg::coord_t     trigger_y;
  pet_pkg::dist_t      trig_dist;
  logic [31:0]         trigger_index;
  logic                last_of_vertex;
  logic                overrun;
  modport source (output valid, trigger_x, trigger_y, trig_dist,
                  trigger_index, last_of_vertex, overrun, input ready);
  modport sink   (input valid, trigger_x, trigger_y, trig_dist,
                  trigger_index, last_of_vertex, overrun, output ready);
endinterface

interface pet_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/polyline_equidistant_trigger_placer.sv
// ----------------------------------------------------------------------------
// polyline_equidistant_trigger_placer
// Places triggers at equal arc-length spacing along a polyline.
// ----------------------------------------------------------------------------
// Usage:
//   vtx  : one word per polyline vertex (x, y in um, path_start flag).
//   trig : zero to MAX_PER_VERTEX words per vertex, one per trigger.
//   cfg  : trigger spacing in um (0 selects DEFAULT_SPACING); write only
//          while idle. Always ready.
// Flow:
//   A path-start vertex is handled in IDLE alone. Any other vertex goes
//   through the two squares and the 25-step square root, then the trigger
//   count division, then, per trigger, two 52-step divisions for x and y
//   interpolation on the one shared divider, plus multiply and emit.
//   vtx.ready is low while a vertex is in work.
// Reset: spacing returns to 10000 um, the walk is cleared, no vertex held.
// Stall: the last trigger sits in the output register; the block then takes
//   the next vertex but holds further triggers until trig.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_equidistant_trigger_placer #(
  parameter int unsigned MAX_PER_VERTEX  = 64,
  parameter int unsigned DEFAULT_SPACING = 10000
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pet_cfg_if.sink     cfg,
  pet_vertex_if.sink  vtx,
  pet_trigger_if.source trig
);
  import pet_pkg::*;

  localparam logic [SpcW-1:0] DefSpc   = SpcW'(DEFAULT_SPACING);
  localparam logic [SpcW-1:0] ResetSpc = SpcW'(10000);
  localparam logic [6:0]      MaxK     = 7'(MAX_PER_VERTEX);

  typedef enum logic [3:0] {
    IDLE, SQ1, SQ2, RT_GO, RT_WAIT, PLAN, DN_GO, DN_WAIT,
    MX, DX_GO, DX_WAIT, MY, DY_GO, DY_WAIT, EMIT
  } state_t;

  state_t          state;
  logic [SpcW-1:0] spacing;
  logic [SpcW-1:0] spc;
  coord_t          prev_x, prev_y, cur_x, cur_y;
  logic            have_previous;
  dist_t           walked_distance, next_target, end_r, seg_base, t;
  logic [IdxW-1:0] trigger_counter, idx;
  logic [MagW-1:0] magx, magy;
  logic            negx, negy;
  logic [SqW-1:0]  sq;
  logic [LenW-1:0] len;
  logic [DvdW-1:0] num;
  logic [6:0]      k, i;
  logic            over;
  coord_t          tx, ty;

  // datapath nets
  logic signed [CoordW:0] dx_c, dy_c;
  logic [MagW-1:0]  mul_a, mul_b;
  logic [SqW-1:0]   prod;
  logic [LenW-1:0]  off;
  dist_t            end_c;
  logic [DistW:0]   end_sum;
  logic             rt_start, rt_done;
  logic [LenW-1:0]  rt_root;
  logic [LenW+1:0]  rt_rem;
  logic             dv_start, dv_done;
  logic [DvdW-1:0]  dv_dvd, dv_q;
  logic [DvsW-1:0]  dv_dvs, dv_r;
  logic [LenW:0]    n_c;
  logic [DistW:0]   nt_sum;
  logic             neg_sel;
  logic signed [CoordW+1:0] interp_c;
  logic             out_free;

  assign spc      = (spacing != '0) ? spacing : DefSpc;
  assign cfg.ready = 1'b1;
  assign vtx.ready = (state == IDLE);
  assign out_free = !trig.valid || trig.ready;

  assign dx_c = {vtx.vertex_x[CoordW-1], vtx.vertex_x} - {prev_x[CoordW-1], prev_x};
  assign dy_c = {vtx.vertex_y[CoordW-1], vtx.vertex_y} - {prev_y[CoordW-1], prev_y};

  // shared multiplier
  assign off = LenW'(t - seg_base);
  always_comb begin
    unique case (state)
      SQ1:     begin mul_a = magx; mul_b = magx; end
      SQ2:     begin mul_a = magy; mul_b = magy; end
      MX:      begin mul_a = magx; mul_b = off;  end
      default: begin mul_a = magy; mul_b = off;  end
    endcase
  end
  assign prod = mul_a * mul_b;

  // end of segment, saturated
  assign end_sum = {1'b0, walked_distance} + (DistW+1)'(len);
  assign end_c   = end_sum[DistW] ? DistMax : end_sum[DistW-1:0];

  // square root unit
  assign rt_start = (state == RT_GO);
  pet_isqrt u_isqrt (
    .clk, .rst, .start(rt_start), .radicand(sq),
    .done(rt_done), .root(rt_root), .rem(rt_rem)
  );

  // shared divider: trigger count, then interpolation of x and y
  assign dv_start = (state == DN_GO) || (state == DX_GO) || (state == DY_GO);
  always_comb begin
    if (state == DN_GO) begin
      dv_dvd = DvdW'(end_r - next_target);
      dv_dvs = DvsW'(spc);
    end else begin
      dv_dvd = num;
      dv_dvs = {len, 1'b0};
    end
  end
  pet_div u_div (
    .clk, .rst, .start(dv_start), .dividend(dv_dvd), .divisor(dv_dvs),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  assign n_c    = dv_q[LenW:0] + (LenW+1)'(1);
  assign nt_sum = {1'b0, end_r} - (DistW+1)'(dv_r) + (DistW+1)'(spc);

  // prev +/- rounded quotient
  assign neg_sel  = (state == DX_WAIT) ? negx : negy;
  always_comb begin
    if (state == DX_WAIT)
      interp_c = (CoordW+2)'(prev_x);
    else
      interp_c = (CoordW+2)'(prev_y);
    if (neg_sel)
      interp_c = interp_c - $signed({1'b0, dv_q[MagW-1:0]});
    else
      interp_c = interp_c + $signed({1'b0, dv_q[MagW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      spacing         <= ResetSpc;
      prev_x          <= '0;
      prev_y          <= '0;
      walked_distance <= '0;
      next_target     <= DistW'(ResetSpc);
      trigger_counter <= '0;
      have_previous   <= 1'b0;
      trig.valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        spacing <= cfg.data;
      end
      // output word valid: set on emit, cleared when taken
      if (state == EMIT && out_free) begin
        trig.valid <= 1'b1;
      end else if (trig.ready) begin
        trig.valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (vtx.valid) begin
            cur_x <= vtx.vertex_x;
            cur_y <= vtx.vertex_y;
            if (vtx.path_start || !have_previous) begin
              prev_x          <= vtx.vertex_x;
              prev_y          <= vtx.vertex_y;
              walked_distance <= '0;
              next_target     <= DistW'(spc);
              trigger_counter <= '0;
              have_previous   <= 1'b1;
            end else begin
              negx  <= dx_c[CoordW];
              negy  <= dy_c[CoordW];
              magx  <= dx_c[CoordW] ? MagW'(-dx_c) : MagW'(dx_c);
              magy  <= dy_c[CoordW] ? MagW'(-dy_c) : MagW'(dy_c);
              state <= SQ1;
            end
          end
        end
        SQ1: begin
          sq    <= prod;
          state <= SQ2;
        end
        SQ2: begin
          sq    <= sq + prod;
          state <= RT_GO;
        end
        RT_GO: state <= RT_WAIT;
        RT_WAIT: begin
          if (rt_done) begin
            len   <= rt_root + LenW'(rt_rem > (LenW+2)'(rt_root));
            state <= PLAN;
          end
        end
        PLAN: begin
          if (len == '0 || walked_distance == DistMax) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            state  <= IDLE;
          end else begin
            walked_distance <= end_c;
            if (next_target <= end_c && next_target >= walked_distance) begin
              end_r    <= end_c;
              seg_base <= walked_distance;
              state    <= DN_GO;
            end else begin
              prev_x <= cur_x;
              prev_y <= cur_y;
              state  <= IDLE;
            end
          end
        end
        DN_GO: state <= DN_WAIT;
        DN_WAIT: begin
          if (dv_done) begin
            t               <= next_target;
            idx             <= trigger_counter;
            trigger_counter <= trigger_counter + IdxW'(n_c);
            next_target     <= nt_sum[DistW] ? DistMax : nt_sum[DistW-1:0];
            over            <= (n_c > (LenW+1)'(MaxK));
            k               <= (n_c > (LenW+1)'(MaxK)) ? MaxK : n_c[6:0];
            i               <= '0;
            state           <= MX;
          end
        end
        MX, MY: begin
          num   <= {prod, 1'b0} + DvdW'(len);
          state <= (state == MX) ? DX_GO : DY_GO;
        end
        DX_GO: state <= DX_WAIT;
        DY_GO: state <= DY_WAIT;
        DX_WAIT: begin
          if (dv_done) begin
            tx    <= interp_c[CoordW-1:0];
            state <= MY;
          end
        end
        DY_WAIT: begin
          if (dv_done) begin
            ty    <= interp_c[CoordW-1:0];
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            trig.trigger_x      <= tx;
            trig.trigger_y      <= ty;
            trig.trig_dist      <= t;
            trig.trigger_index  <= idx;
            trig.last_of_vertex <= (i + 7'd1 == k);
            trig.overrun        <= over;
            if (i + 7'd1 == k) begin
              prev_x <= cur_x;
              prev_y <= cur_y;
              state  <= IDLE;
            end else begin
              i     <= i + 7'd1;
              t     <= t + DistW'(spc);
              idx   <= idx + IdxW'(1);
              state <= MX;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pet_isqrt.sv
// ----------------------------------------------------------------------------
// pet_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_isqrt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [pet_pkg::SqW-1:0]  radicand,
  output logic                          done,
  output logic [pet_pkg::LenW-1:0]      root,
  output logic [pet_pkg::LenW+1:0]      rem
);
  import pet_pkg::*;

  localparam int unsigned Steps = SqW / 2;

  logic [SqW-1:0]  val;
  logic [4:0]      cnt;
  logic            busy;
  logic [LenW+2:0] cur;
  logic [LenW+2:0] trial;

  // one root digit per cycle
  assign cur   = {rem[LenW:0], val[SqW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      val  <= radicand;
      root <= '0;
      rem  <= '0;
      cnt  <= 5'(Steps - 1);
    end else if (busy) begin
      val <= {val[SqW-3:0], 2'b00};
      if (cur >= trial) begin
        rem  <= (LenW+2)'(cur - trial);
        root <= {root[LenW-2:0], 1'b1};
      end else begin
        rem  <= (LenW+2)'(cur);
        root <= {root[LenW-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt - 5'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pet_div.sv
// ----------------------------------------------------------------------------
// pet_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [pet_pkg::DvdW-1:0] dividend,
  input  wire logic [pet_pkg::DvsW-1:0] divisor,
  output logic                          done,
  output logic [pet_pkg::DvdW-1:0]      quotient,
  output logic [pet_pkg::DvsW-1:0]      remainder
);
  import pet_pkg::*;

  logic [DvsW-1:0] dvs;
  logic [5:0]      cnt;
  logic            busy;
  logic [DvsW:0]   cur;

  // shift in the next dividend bit (held in the quotient register)
  assign cur = {remainder, quotient[DvdW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      quotient  <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      cnt       <= 6'(DvdW - 1);
    end else if (busy) begin
      if (cur >= {1'b0, dvs}) begin
        remainder <= DvsW'(cur - {1'b0, dvs});
        quotient  <= {quotient[DvdW-2:0], 1'b1};
      end else begin
        remainder <= cur[DvsW-1:0];
        quotient  <= {quotient[DvdW-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt - 6'd1;
    end
  end

endmodule

`default_nettype wire

// File: verif/polyline_equidistant_trigger_placer_tb.sv
// ----------------------------------------------------------------------------
// polyline_equidistant_trigger_placer_tb
// Self-checking bench for the trigger placer. A directed table of vertices
// (first vertex without a path start, zero-length and short segments,
// coordinate extremes, overrun) is followed by random polylines at several
// spacings (reset value, zero, one, maximum, random). Every trigger word is
// checked against a local arc-length predictor (or a typed-in word for a
// typed row), with bursty vertex traffic and a changing stall pattern on the trigger side.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_equidistant_trigger_placer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pet_pkg::*;

  localparam int unsigned MaxPerVertex   = 64;
  localparam int unsigned DefaultSpacing = 10000;
  localparam longint unsigned CycleLimit = 10_000_000;
  localparam longint CoordMax = 8388607;
  localparam longint CoordMin = -8388608;

  typedef struct {
    coord_t      x;
    coord_t      y;
    dist_t       distance;
    logic [31:0] idx;
    logic        last;
    logic        over;
  } trig_word_t;

  typedef struct {
    coord_t     x;
    coord_t     y;
    logic       start;
    logic       typed;   // use the typed-in trigger below instead of the predictor
    trig_word_t trig;
  } vertex_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pet_cfg_if     cfg_ch ();
  pet_vertex_if  vtx_ch ();
  pet_trigger_if trig_ch ();

  polyline_equidistant_trigger_placer u_top (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .vtx  (vtx_ch),
    .trig (trig_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0]     spacing_reg;
  longint          last_x, last_y;
  longint unsigned walked, target;
  logic [31:0]     trig_count;
  logic            have_prev;

  trig_word_t      pending_triggers[$];
  int unsigned     errors;
  longint unsigned cycles;
  int unsigned     burst_left;
  longint          pos_x, pos_y;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // base + round(delta * off / len), ties away from zero
  function automatic coord_t lerp(input longint base, input longint delta,
                                  input longint unsigned off,
                                  input longint unsigned len);
    longint unsigned mag, q;
    mag = (delta < 0) ? -delta : delta;
    q   = (mag * off * 2 + len) / (len * 2);
    return (delta < 0) ? coord_t'(base - longint'(q)) : coord_t'(base + longint'(q));
  endfunction

  function automatic void reset_walk();
    spacing_reg = 24'd10000;
    last_x = 0;
    last_y = 0;
    walked = 0;
    target = 10000;
    trig_count = '0;
    have_prev = 1'b0;
  endfunction

  // triggers caused by one vertex; updates the walk
  function automatic void place_triggers(input coord_t x, input coord_t y,
                                         input logic start,
                                         output trig_word_t res[$]);
    longint unsigned s, sq, len, endd, n, k, t, off;
    longint dx, dy;
    trig_word_t w;
    res = {};
    s = (spacing_reg != 0) ? spacing_reg : DefaultSpacing;
    if (start || !have_prev) begin
      last_x = x;
      last_y = y;
      walked = 0;
      target = s;
      trig_count = '0;
      have_prev = 1'b1;
      return;
    end
    dx  = longint'(x) - last_x;
    dy  = longint'(y) - last_y;
    sq  = dx * dx + dy * dy;
    len = isqrt(sq);
    if (sq > len * len + len) len++;
    if (len != 0 && walked < DistMax) begin
      endd = walked + len;
      if (endd > DistMax) endd = DistMax;
      if (target <= endd && target >= walked) begin
        n = (endd - target) / s + 1;
        k = (n > MaxPerVertex) ? MaxPerVertex : n;
        for (longint unsigned i = 0; i < k; i++) begin
          t          = target + i * s;
          off        = t - walked;
          w.x        = lerp(last_x, dx, off, len);
          w.y        = lerp(last_y, dy, off, len);
          w.distance = dist_t'(t);
          w.idx      = trig_count + 32'(i);
          w.last     = (i + 1 == k);
          w.over     = (n > MaxPerVertex);
          res        = {res, w};
        end
        trig_count = trig_count + 32'(n);
        target = target + n * s;
        if (target > DistMax) target = DistMax;
      end
      walked = endd;
    end
    last_x = x;
    last_y = y;
  endfunction

  // drive one vertex word, called at a falling edge
  task automatic send_vertex(input coord_t x, input coord_t y, input logic start,
                             input logic typed, input trig_word_t trig);
    trig_word_t res[$];
    vtx_ch.vertex_x   = x;
    vtx_ch.vertex_y   = y;
    vtx_ch.path_start = start;
    vtx_ch.valid      = 1'b1;
    do @(posedge clk); while (!vtx_ch.ready);
    place_triggers(x, y, start, res);
    if (typed) res = '{trig};
    pending_triggers = {pending_triggers, res};
    @(negedge clk);
    if (burst_left == 0) begin
      vtx_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4))
        @(negedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // wait until the block has drained, then write the spacing register
  task automatic write_spacing(input logic [23:0] value);
    vtx_ch.valid = 1'b0;
    while (pending_triggers.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    spacing_reg = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // random polyline at the current spacing; scale bounds the step per axis, apart from full-range jumps
  task automatic random_walk(input int unsigned items, input longint scale);
    longint nx, ny, dx, dy;
    trig_word_t none;
    none = '{default: '0};
    for (int unsigned i = 0; i < items; i++) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // full-range jump
        nx = longint'(coord_t'($urandom));
        ny = longint'(coord_t'($urandom));
      end else if (pick < 9) begin
        nx = pos_x;
        ny = pos_y;
      end else begin
        dx = longint'($urandom_range(0, 32'(scale)));
        dy = longint'($urandom_range(0, 32'(scale)));
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        nx = pos_x + dx;
        ny = pos_y + dy;
        if (nx > CoordMax || nx < CoordMin) nx = pos_x - dx;
        if (ny > CoordMax || ny < CoordMin) ny = pos_y - dy;
      end
      pos_x = nx;
      pos_y = ny;
      send_vertex(coord_t'(nx), coord_t'(ny), ($urandom_range(0, 9) == 0), 1'b0, none);
    end
  endtask

  // directed vertex table at the reset spacing of 10000 um
  vertex_row_t directed[] = '{
    '{x:  7, y: -3, start: 0, typed: 0, trig: '{default: '0}},
    '{x:  0, y:  0, start: 1, typed: 0, trig: '{default: '0}},
    '{x: 10000, y: 0, start: 0, typed: 1,
      trig: '{x: 10000, y: 0, distance: 10000, idx: 0, last: 1, over: 0}},
    '{x: 10000, y: 0,    start: 0, typed: 0, trig: '{default: '0}},
    '{x: 10000, y: 5000, start: 0, typed: 0, trig: '{default: '0}},
    '{x: 10000, y: 0,    start: 0, typed: 0, trig: '{default: '0}},
    '{x:  8388607, y:  8388607, start: 0, typed: 0, trig: '{default: '0}},
    '{x: -8388608, y: -8388608, start: 0, typed: 0, trig: '{default: '0}},
    '{x: -8388608, y:  8388607, start: 1, typed: 0, trig: '{default: '0}},
    '{x:  8388607, y: -8388608, start: 0, typed: 0, trig: '{default: '0}},
    '{x:  0, y: 0, start: 1, typed: 0, trig: '{default: '0}},
    '{x:  3, y: 4, start: 0, typed: 0, trig: '{default: '0}},
    '{x: -30000, y:  0, start: 0, typed: 0, trig: '{default: '0}},
    '{x: -30000, y: -1, start: 0, typed: 0, trig: '{default: '0}},
    '{x: -14999, y: 7, start: 0, typed: 0, trig: '{default: '0}}
  };

  // stimulus
  initial begin
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    vtx_ch.valid      = 1'b0;
    vtx_ch.vertex_x   = '0;
    vtx_ch.vertex_y   = '0;
    vtx_ch.path_start = 1'b0;
    errors     = 0;
    burst_left = 0;
    pos_x = 0;
    pos_y = 0;
    reset_walk();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_vertex(directed[i].x, directed[i].y, directed[i].start,
                  directed[i].typed, directed[i].trig);

    // random polylines; spacing changes keep the path alive
    random_walk(30, 25000);
    write_spacing(24'd0);
    random_walk(30, 20000);
    write_spacing(24'd1);
    random_walk(30, 40);
    write_spacing(24'hFFFFFF);
    random_walk(30, 8388607);
    write_spacing(24'($urandom_range(100, 20000)));
    random_walk(30, 30000);
    write_spacing(24'($urandom_range(1, 24'hFFFFFF)));
    random_walk(15, 8388607);
    write_spacing(24'd10000);
    random_walk(25, 25000);

    vtx_ch.valid = 1'b0;
    while (pending_triggers.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // trigger side stall pattern, re-chosen when the low eight bits of the cycle count are zero
  int unsigned stall_mode, stall_period, stall_low;
  initial begin
    trig_ch.ready = 1'b0;
    stall_mode = 0;
    stall_period = 4;
    stall_low = 1;
  end
  always @(negedge clk) begin
    if (cycles[7:0] == 0) begin
      stall_mode   = $urandom_range(0, 2);
      stall_period = $urandom_range(2, 30);
      stall_low    = $urandom_range(1, stall_period - 1);
    end
    case (stall_mode)
      0: trig_ch.ready = 1'b1;
      1: trig_ch.ready = $urandom_range(0, 1);
      default: trig_ch.ready = (cycles % stall_period) >= stall_low;
    endcase
  end

  // trigger checker
  always @(posedge clk) begin
    trig_word_t exp_w;
    if (!rst && trig_ch.valid && trig_ch.ready) begin
      if (pending_triggers.size() == 0) begin
        $display("%0t: unexpected trigger word x=%0d y=%0d dist=%0d idx=%0d",
                 $time, trig_ch.trigger_x, trig_ch.trigger_y,
                 trig_ch.trig_dist, trig_ch.trigger_index);
        errors++;
      end else begin
        exp_w = pending_triggers.pop_front();
        if (trig_ch.trigger_x !== exp_w.x) begin
          $display("%0t: trigger_x exp %0d got %0d", $time, exp_w.x, trig_ch.trigger_x);
          errors++;
        end
        if (trig_ch.trigger_y !== exp_w.y) begin
          $display("%0t: trigger_y exp %0d got %0d", $time, exp_w.y, trig_ch.trigger_y);
          errors++;
        end
        if (trig_ch.trig_dist !== exp_w.distance) begin
          $display("%0t: trig_dist exp %0d got %0d", $time, exp_w.distance,
                   trig_ch.trig_dist);
          errors++;
        end
        if (trig_ch.trigger_index !== exp_w.idx) begin
          $display("%0t: trigger_index exp %0d got %0d", $time, exp_w.idx,
                   trig_ch.trigger_index);
          errors++;
        end
        if (trig_ch.last_of_vertex !== exp_w.last) begin
          $display("%0t: last_of_vertex exp %0b got %0b", $time, exp_w.last,
                   trig_ch.last_of_vertex);
          errors++;
        end
        if (trig_ch.overrun !== exp_w.over) begin
          $display("%0t: overrun exp %0b got %0b", $time, exp_w.over, trig_ch.overrun);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d trigger words still pending", $time,
               pending_triggers.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pet_pkg.sv
hw/rtl/pet_if.sv
hw/rtl/pet_isqrt.sv
hw/rtl/pet_div.sv
hw/rtl/polyline_equidistant_trigger_placer.sv
verif/polyline_equidistant_trigger_placer_tb.sv
